>>> hw/rtl/modexp_pkg.sv
`timescale 1ns / 1ps

package modexp_pkg;

  localparam int unsigned WIDTH      = 32;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned EXP_W      = 32;
  localparam int unsigned CNT_W      = $clog2(WIDTH + 1);
  localparam int unsigned CFG_IDX_W  = 1;

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPONENT = 1'b0,
    CFG_MODULUS  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RED,
    ST_BIT,
    ST_MUL,
    ST_NEXT,
    ST_SQ,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mm_req_t;

endpackage

>>> hw/rtl/modexp_mulmod.sv
`timescale 1ns / 1ps

module modexp_mulmod import modexp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mm_req_t req_i,
  input  word_t   m_i,
  output logic    done_o,
  output word_t   prod_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  word_t            a_q, a_d;
  word_t            b_q, b_d;
  word_t            r_q, r_d;

  word_t            ax;
  logic [WIDTH+1:0] s0, m1, m2, sub1, sub2;

  // One multiplier bit per cycle, most significant first: r = 2r + bit * a, kept below m.
  // A zero modulus leaves the sum wrapping at the operand width.
  always_comb begin
    ax   = b_q[WIDTH-1] ? a_q : '0;
    s0   = {1'b0, r_q, 1'b0} + {2'b00, ax};
    m1   = {2'b00, m_i};
    m2   = {1'b0, m_i, 1'b0};
    sub1 = s0 - m1;
    sub2 = s0 - m2;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH);
      a_d    = req_i.a;
      b_d    = req_i.b;
      r_d    = '0;
    end else if (busy_q) begin
      b_d   = b_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (m_i == '0) begin
        r_d = s0[WIDTH-1:0];
      end else if (s0 >= m2) begin
        r_d = sub2[WIDTH-1:0];
      end else if (s0 >= m1) begin
        r_d = sub1[WIDTH-1:0];
      end else begin
        r_d = s0[WIDTH-1:0];
      end
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

>>> hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps

// Raises each message beat to the configured exponent modulo the configured modulus by
// right-to-left square-and-multiply; a zero exponent returns 1 and a zero modulus lets
// products wrap at WIDTH bits. All modular products run on one bit-serial multiplier.
// Each item first reduces the message, then walks the exponent from its least significant
// bit, multiplying into the accumulator for every set bit and squaring for every bit below
// the top set bit; a zero exponent skips every product. The input is not ready while an
// item is being worked on; a finished result waits in an output register so the next
// message can be taken.
// Configuration writes are always accepted and must only occur while the block is idle.

module modular_exponentiation import modexp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FIELD_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FIELD_W-1:0]   message_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FIELD_W-1:0]   power_result_o
);

  state_e               state_q, state_d;
  logic [EXP_W-1:0]     exponent_q, exponent_d;
  logic [FIELD_W-1:0]   modulus_value_q, modulus_value_d;
  logic [EXP_W-1:0]     exp_q, exp_d;
  word_t                msg_q, msg_d;
  word_t                acc_q, acc_d;
  word_t                sq_q, sq_d;
  logic                 out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]   out_q, out_d;

  word_t                mod_w;
  word_t                one_red;
  mm_req_t              req;
  logic                 mm_done;
  word_t                mm_prod;
  logic                 in_beat;
  logic                 fin_go;

  assign mod_w   = WIDTH'(modulus_value_q);
  assign one_red = (mod_w == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign in_beat = in_valid_i && (state_q == ST_IDLE);
  assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  modexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .m_i    (mod_w),
    .done_o (mm_done),
    .prod_o (mm_prod)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (exponent_q == '0) ? ST_FIN : ST_INIT;
        end
      end
      ST_INIT: state_d = ST_RED;
      ST_RED: begin
        if (mm_done) begin
          state_d = ST_BIT;
        end
      end
      ST_BIT: state_d = exp_q[0] ? ST_MUL : ST_NEXT;
      ST_MUL: begin
        if (mm_done) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: state_d = (exp_q[EXP_W-1:1] == '0) ? ST_FIN : ST_SQ;
      ST_SQ: begin
        if (mm_done) begin
          state_d = ST_BIT;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req.start  = 1'b0;
    req.a      = sq_q;
    req.b      = sq_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_INIT: begin
        req.start = 1'b1;
        req.a     = one_red;
        req.b     = msg_q;
      end
      ST_BIT: begin
        req.start = exp_q[0];
        req.a     = acc_q;
      end
      ST_NEXT: req.start = (exp_q[EXP_W-1:1] != '0);
      default: req.start = 1'b0;
    endcase
  end

  always_comb begin
    exponent_d      = exponent_q;
    modulus_value_d = modulus_value_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_EXPONENT: exponent_d      = cfg_data_i;
        CFG_MODULUS:  modulus_value_d = cfg_data_i;
        default:      exponent_d      = exponent_q;
      endcase
    end
  end

  always_comb begin
    exp_d       = exp_q;
    msg_d       = msg_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_beat) begin
      exp_d = exponent_q;
      msg_d = WIDTH'(message_i);
      acc_d = (exponent_q == '0) ? WIDTH'(1) : one_red;
    end
    if (mm_done && ((state_q == ST_RED) || (state_q == ST_SQ))) begin
      sq_d = mm_prod;
    end
    if (mm_done && (state_q == ST_MUL)) begin
      acc_d = mm_prod;
    end
    if (state_q == ST_NEXT) begin
      exp_d = exp_q >> 1;
    end
    if (fin_go) begin
      out_d       = FIELD_W'(acc_q);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      exponent_q      <= EXP_W'(1);
      modulus_value_q <= FIELD_W'(1);
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      exponent_q      <= exponent_d;
      modulus_value_q <= modulus_value_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    msg_q <= msg_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    out_q <= out_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

endmodule
